[rtl/core/cgp_pkg.sv]
package cgp_pkg;

    // Operation codes carried on the input tuser
    localparam logic [2:0] OP_GRANT   = 3'd0;
    localparam logic [2:0] OP_TOUCH   = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_REL_ALL = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_ADD     = 3'd5;
    localparam logic [2:0] OP_QUERY   = 3'd6;
    localparam logic [2:0] OP_BAD     = 3'd7;

    // Result kinds carried on the output tuser
    localparam logic [1:0] KIND_ANSWER = 2'd0;
    localparam logic [1:0] KIND_NOTICE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam int ID_W      = 24;
    localparam int CH_W      = 12;
    localparam int TMO_W     = 16;
    localparam int MS_W      = 16;
    localparam int ELAPSED_W = 27;
    localparam int ACTIVE_W  = 5;

    // One grant table entry as stored in the slot memory
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic [TMO_W-1:0]     timeout;
        logic [CH_W-1:0]      channel;
        logic [ID_W-1:0]      source;
        logic [ID_W-1:0]      dest;
    } t_slot;

endpackage

[rtl/core/cgp_ram.sv]
module cgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/channel_grant_pool_with_timeouts.sv]
// Channel grant pool with lease timeouts. A FIFO of free channels and a table of
// GRANT_SLOTS grants live in two single-port-write memories with registered reads;
// slot valid bits sit in flip-flops. Input transfers on s_* carry the operation in
// tuser; each produces one or more results on m_*, the final one with tlast.
// Grant, touch, release and query walk the slot memory one entry at a time (read,
// then evaluate), stopping early on a matching destination; release_all and tick
// walk every entry, with a release step per freed slot and, for tick, a timeout
// check per valid slot; add_channel and rejects skip the walk. Output stalls hold it.
// Only one item is in work at a time; s_tready is high while the block is idle.
// No clearing pass is needed after reset.
module channel_grant_pool_with_timeouts
    import cgp_pkg::*;
#(
    parameter int POOL_DEPTH       = 16,
    parameter int GRANT_SLOTS      = 16,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // dest_id, source_id, timeout_seconds, elapsed_ms, channel_in, 4'b0 pad
    input  logic [95:0] s_tdata,
    // operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // success, channel_out, dest_out, source_out, active_grants, 6'b0 pad
    output logic [71:0] m_tdata,
    // kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int PAW  = POOL_DEPTH > 1 ? $clog2(POOL_DEPTH) : 1;
    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int SAW  = GRANT_SLOTS > 1 ? $clog2(GRANT_SLOTS) : 1;
    localparam int GTW  = $clog2(GRANT_SLOTS + 1);
    localparam int TW   = $clog2(TICKS_PER_SECOND + 1);
    localparam int PW   = TMO_W + TW;
    localparam int CMPW = PW > ELAPSED_W ? PW : ELAPSED_W;
    localparam int SW   = $bits(t_slot);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_TK   = 4'd4;
    localparam logic [3:0] S_REL  = 4'd5;
    localparam logic [3:0] S_GEM  = 4'd6;
    localparam logic [3:0] S_ONE  = 4'd7;
    localparam logic [3:0] S_END  = 4'd8;

    // Control state
    logic [3:0]             r_state, n_state;
    logic [PAW-1:0]         r_head, n_head;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [GTW-1:0]         r_gtot, n_gtot;
    logic [GRANT_SLOTS-1:0] r_valid, n_valid;
    logic                   r_o_valid, n_o_valid;

    // Item and work payload
    logic [2:0]           r_op;
    logic [ID_W-1:0]      r_dest, r_src;
    logic [TMO_W-1:0]     r_tmo;
    logic [MS_W-1:0]      r_ms;
    logic [CH_W-1:0]      r_chin;
    logic [SAW-1:0]       r_idx, n_idx;
    logic                 r_free_ok, n_free_ok;
    logic [SAW-1:0]       r_free_idx, n_free_idx;
    logic [SAW-1:0]       r_tgt, n_tgt;
    t_slot                r_word, n_word;
    logic [CH_W-1:0]      r_ch, n_ch;
    logic                 r_new, n_new;
    logic                 r_popped, n_popped;
    logic [ELAPSED_W-1:0] r_e, n_e;
    logic [PW-1:0]        r_thr, n_thr;
    logic [1:0]           r_a_kind, n_a_kind;
    logic                 r_a_ok, n_a_ok;
    logic [CH_W-1:0]      r_a_ch, n_a_ch;
    logic [ID_W-1:0]      r_a_dest, n_a_dest;
    logic [ID_W-1:0]      r_a_src, n_a_src;
    logic                 r_a_add, n_a_add;
    logic [71:0]          r_o_data, n_o_data;
    logic [1:0]           r_o_kind, n_o_kind;
    logic                 r_o_last, n_o_last;

    // Memory ports
    t_slot            slot_rd;
    t_slot            slot_wd;
    logic             slot_we;
    logic [SAW-1:0]   slot_wa;
    logic [CH_W-1:0]  pool_rd;
    logic             pool_we;
    logic [CH_W-1:0]  pool_wd;
    logic [SW-1:0]    slot_rd_bits;

    logic             out_free;
    logic             in_xfer;
    logic             last_idx;
    logic             cur_valid;
    logic [CW:0]      tail_sum;
    logic [PAW-1:0]   tail;
    logic [PAW-1:0]   head_inc;
    logic [ELAPSED_W:0] e_sum;
    logic [ELAPSED_W-1:0] e_sat;
    logic             hit;
    logic             reject;

    cgp_ram #(.WIDTH(SW), .DEPTH(GRANT_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_wa),
        .i_wdata (slot_wd),
        .i_raddr (r_idx),
        .o_rdata (slot_rd_bits)
    );
    assign slot_rd = t_slot'(slot_rd_bits);

    cgp_ram #(.WIDTH(CH_W), .DEPTH(POOL_DEPTH)) u_pool_ram (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (tail),
        .i_wdata (pool_wd),
        .i_raddr (r_head),
        .o_rdata (pool_rd)
    );

    assign s_tready = (r_state == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !r_o_valid || m_tready;
    assign m_tvalid = r_o_valid;
    assign m_tdata  = r_o_data;
    assign m_tuser  = r_o_kind;
    assign m_tlast  = r_o_last;

    // Pool tail and head arithmetic
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_cnt);
    assign tail     = (tail_sum >= (CW+1)'(POOL_DEPTH))
                    ? PAW'(tail_sum - (CW+1)'(POOL_DEPTH)) : PAW'(tail_sum);
    assign head_inc = (r_head == PAW'(POOL_DEPTH - 1)) ? '0 : PAW'(r_head + 1'b1);

    assign last_idx  = (r_idx == SAW'(GRANT_SLOTS - 1));
    assign cur_valid = r_valid[r_idx];
    assign hit       = cur_valid && (slot_rd.dest == r_dest);
    assign e_sum     = (ELAPSED_W+1)'(slot_rd.elapsed) + (ELAPSED_W+1)'(r_ms);
    assign e_sat     = e_sum[ELAPSED_W] ? '1 : e_sum[ELAPSED_W-1:0];
    assign reject    = (((r_op == OP_GRANT) || (r_op == OP_TOUCH) || (r_op == OP_RELEASE)
                        || (r_op == OP_QUERY)) && (r_dest == '0))
                     || ((r_op == OP_ADD) && (r_chin == '0)) || (r_op == OP_BAD);

    function automatic logic [71:0] pack_out(input logic ok, input logic [CH_W-1:0] ch,
                                             input logic [ID_W-1:0] dst,
                                             input logic [ID_W-1:0] src,
                                             input logic [ACTIVE_W-1:0] act);
        pack_out = {6'd0, act, src, dst, ch, ok};
    endfunction

    // Sequencer: walk the slot memory, modify and write back
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_gtot     = r_gtot;
        n_valid    = r_valid;
        n_o_valid  = r_o_valid && !m_tready;
        n_idx      = r_idx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_tgt      = r_tgt;
        n_word     = r_word;
        n_ch       = r_ch;
        n_new      = r_new;
        n_popped   = r_popped;
        n_e        = r_e;
        n_thr      = r_thr;
        n_a_kind   = r_a_kind;
        n_a_ok     = r_a_ok;
        n_a_ch     = r_a_ch;
        n_a_dest   = r_a_dest;
        n_a_src    = r_a_src;
        n_a_add    = r_a_add;
        n_o_data   = r_o_data;
        n_o_kind   = r_o_kind;
        n_o_last   = r_o_last;
        slot_we    = 1'b0;
        slot_wa    = r_idx;
        slot_wd    = slot_rd;
        pool_we    = 1'b0;
        pool_wd    = r_word.channel;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_idx     = '0;
                n_free_ok = 1'b0;
                n_a_add   = 1'b0;
                if (reject) begin
                    n_a_kind = KIND_REJECT;
                    n_a_ok   = 1'b0;
                    n_a_ch   = '0;
                    n_a_dest = '0;
                    n_a_src  = '0;
                    n_state  = S_ONE;
                end else if (r_op == OP_ADD) begin
                    n_a_kind = KIND_ANSWER;
                    n_a_ok   = (r_cnt < CW'(POOL_DEPTH));
                    n_a_add  = (r_cnt < CW'(POOL_DEPTH));
                    n_a_ch   = r_chin;
                    n_a_dest = '0;
                    n_a_src  = '0;
                    n_state  = S_ONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                case (r_op)
                    OP_REL_ALL: begin
                        n_word = slot_rd;
                        if (cur_valid) begin
                            n_state = S_REL;
                        end else if (last_idx) begin
                            n_state = S_END;
                        end else begin
                            n_idx   = SAW'(r_idx + 1'b1);
                            n_state = S_RD;
                        end
                    end
                    OP_TICK: begin
                        n_word         = slot_rd;
                        n_word.elapsed = e_sat;
                        n_e            = e_sat;
                        n_thr          = PW'(slot_rd.timeout) * PW'(TICKS_PER_SECOND);
                        if (cur_valid) begin
                            slot_we         = 1'b1;
                            slot_wd.elapsed = e_sat;
                            n_state         = S_TK;
                        end else if (last_idx) begin
                            n_state = S_END;
                        end else begin
                            n_idx   = SAW'(r_idx + 1'b1);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_a_kind = KIND_ANSWER;
                        n_a_dest = r_dest;
                        if (hit) begin
                            n_word = slot_rd;
                            n_tgt  = r_idx;
                            n_new  = 1'b0;
                            if (r_op == OP_GRANT) begin
                                n_popped = (r_cnt != '0);
                                n_ch     = (r_cnt != '0) ? pool_rd : slot_rd.channel;
                                n_state  = S_GEM;
                            end else if (r_op == OP_RELEASE) begin
                                n_state = S_REL;
                            end else begin
                                n_a_ok  = 1'b1;
                                n_a_ch  = slot_rd.channel;
                                n_a_src = slot_rd.source;
                                if (r_op == OP_TOUCH) begin
                                    slot_we         = 1'b1;
                                    slot_wd.elapsed = '0;
                                end
                                n_state = S_ONE;
                            end
                        end else begin
                            if (!cur_valid && !r_free_ok) begin
                                n_free_ok  = 1'b1;
                                n_free_idx = r_idx;
                            end
                            if (last_idx) begin
                                n_a_ok  = 1'b0;
                                n_a_ch  = '0;
                                n_a_src = '0;
                                n_state = S_ONE;
                                if ((r_op == OP_GRANT) && (r_free_ok || !cur_valid)
                                    && (r_cnt != '0)) begin
                                    n_new    = 1'b1;
                                    n_popped = 1'b1;
                                    n_tgt    = r_free_ok ? r_free_idx : r_idx;
                                    n_ch     = pool_rd;
                                    n_state  = S_GEM;
                                end
                            end else begin
                                n_idx   = SAW'(r_idx + 1'b1);
                                n_state = S_RD;
                            end
                        end
                    end
                endcase
            end
            S_TK: begin
                if ((r_word.timeout != '0) && (CMPW'(r_e) >= CMPW'(r_thr))) begin
                    n_state = S_REL;
                end else if (last_idx) begin
                    n_state = S_END;
                end else begin
                    n_idx   = SAW'(r_idx + 1'b1);
                    n_state = S_RD;
                end
            end
            S_REL: begin
                if (out_free) begin
                    if (r_cnt < CW'(POOL_DEPTH)) begin
                        pool_we = 1'b1;
                        n_cnt   = CW'(r_cnt + 1'b1);
                    end
                    n_valid[r_idx] = 1'b0;
                    if (r_gtot != '0) begin
                        n_gtot = GTW'(r_gtot - 1'b1);
                    end
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_NOTICE;
                    n_o_data  = pack_out(1'b1, r_word.channel, r_word.dest, r_word.source,
                                         ACTIVE_W'(n_gtot));
                    n_o_last  = (r_op == OP_RELEASE);
                    if (r_op == OP_RELEASE) begin
                        n_state = S_IDLE;
                    end else if (last_idx) begin
                        n_state = S_END;
                    end else begin
                        n_idx   = SAW'(r_idx + 1'b1);
                        n_state = S_RD;
                    end
                end
            end
            S_GEM: begin
                if (out_free) begin
                    slot_we = 1'b1;
                    slot_wa = r_tgt;
                    slot_wd = '{elapsed: '0, timeout: r_tmo, channel: r_ch,
                                source: r_src, dest: r_dest};
                    if (r_popped) begin
                        n_head = head_inc;
                        if (r_new) begin
                            n_cnt = CW'(r_cnt - 1'b1);
                        end else begin
                            // Old channel goes to the tail, count stays
                            pool_we = 1'b1;
                        end
                    end
                    if (r_new) begin
                        n_valid[r_tgt] = 1'b1;
                        n_gtot         = GTW'(r_gtot + 1'b1);
                    end
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_ANSWER;
                    n_o_data  = pack_out(1'b1, r_ch, r_dest, r_src, ACTIVE_W'(n_gtot));
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_ONE: begin
                if (out_free) begin
                    if (r_a_add) begin
                        pool_we = 1'b1;
                        pool_wd = r_chin;
                        n_cnt   = CW'(r_cnt + 1'b1);
                    end
                    n_o_valid = 1'b1;
                    n_o_kind  = r_a_kind;
                    n_o_data  = pack_out(r_a_ok, r_a_ch, r_a_dest, r_a_src,
                                         ACTIVE_W'(r_gtot));
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_END;
                    n_o_data  = pack_out(1'b1, '0, '0, '0, ACTIVE_W'(r_gtot));
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_cnt     <= '0;
            r_gtot    <= '0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_cnt     <= n_cnt;
            r_gtot    <= n_gtot;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= s_tuser;
            r_dest <= s_tdata[23:0];
            r_src  <= s_tdata[47:24];
            r_tmo  <= s_tdata[63:48];
            r_ms   <= s_tdata[79:64];
            r_chin <= s_tdata[91:80];
        end
        r_idx      <= n_idx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_tgt      <= n_tgt;
        r_word     <= n_word;
        r_ch       <= n_ch;
        r_new      <= n_new;
        r_popped   <= n_popped;
        r_e        <= n_e;
        r_thr      <= n_thr;
        r_a_kind   <= n_a_kind;
        r_a_ok     <= n_a_ok;
        r_a_ch     <= n_a_ch;
        r_a_dest   <= n_a_dest;
        r_a_src    <= n_a_src;
        r_a_add    <= n_a_add;
        r_o_data   <= n_o_data;
        r_o_kind   <= n_o_kind;
        r_o_last   <= n_o_last;
    end

    // Pool never overfills
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(POOL_DEPTH))
        else $error("pool count above depth");

    // Grant total tracks the valid bits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gtot == GTW'($countones(r_valid)))
        else $error("grant total out of step with slot valid bits");

    // An accepted item moves straight to decode
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DEC))
        else $error("accepted item not decoded");

    // A new grant claims an empty slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEM) && r_new |-> !r_valid[r_tgt])
        else $error("new grant targets an occupied slot");

endmodule

[tb/sv/channel_grant_pool_with_timeouts_chk.sv]
`timescale 1ns / 1ps

// Watches both streams, predicts every result of the grant pool and compares
module channel_grant_pool_with_timeouts_chk
    import cgp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int POOL_N  = 16;
    localparam int SLOT_N  = 16;
    localparam int TPS     = 1000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

    typedef struct packed {
        logic [1:0]          kind;
        logic                ok;
        logic [CH_W-1:0]     ch;
        logic [ID_W-1:0]     dest;
        logic [ID_W-1:0]     src;
        logic [ACTIVE_W-1:0] active;
        logic                last;
    } t_result;

    // Mirror of the pool and the grant table
    logic [CH_W-1:0]      free_ch [POOL_N];
    int                   head;
    int                   count;
    logic                 used    [SLOT_N];
    logic [ID_W-1:0]      g_dest  [SLOT_N];
    logic [ID_W-1:0]      g_src   [SLOT_N];
    logic [CH_W-1:0]      g_ch    [SLOT_N];
    logic [TMO_W-1:0]     g_tmo   [SLOT_N];
    logic [ELAPSED_W-1:0] g_elap  [SLOT_N];
    int                   granted;

    t_result expected_results [$];

    assign o_pending = expected_results.size();

    task automatic add_result(logic [1:0] kind, logic ok, logic [CH_W-1:0] ch,
                              logic [ID_W-1:0] dest, logic [ID_W-1:0] src);
        t_result r;
        r.kind   = kind;
        r.ok     = ok;
        r.ch     = ch;
        r.dest   = dest;
        r.src    = src;
        r.active = granted[ACTIVE_W-1:0];
        r.last   = 1'b0;
        expected_results = {expected_results, r};
    endtask

    task automatic pool_push(logic [CH_W-1:0] ch);
        if (count < POOL_N) begin
            free_ch[(head + count) % POOL_N] = ch;
            count++;
        end
    endtask

    task automatic pool_pop(output logic [CH_W-1:0] ch);
        ch = free_ch[head];
        head = (head + 1) % POOL_N;
        count--;
    endtask

    function automatic int lookup(logic [ID_W-1:0] dest);
        for (int s = 0; s < SLOT_N; s++)
            if (used[s] && g_dest[s] == dest) return s;
        return -1;
    endfunction

    task automatic free_slot(int s);
        pool_push(g_ch[s]);
        used[s] = 1'b0;
        if (granted > 0) granted--;
        add_result(KIND_NOTICE, 1'b1, g_ch[s], g_dest[s], g_src[s]);
    endtask

    // Work out every result of one accepted transfer
    task automatic predict_grant_pool(logic [2:0] op, logic [ID_W-1:0] dest,
                                      logic [ID_W-1:0] src, logic [TMO_W-1:0] tmo,
                                      logic [MS_W-1:0] ms, logic [CH_W-1:0] chin);
        int s;
        logic [CH_W-1:0] ch;
        logic [ELAPSED_W:0] sum;
        logic expired [SLOT_N];
        if (((op == OP_GRANT || op == OP_TOUCH || op == OP_RELEASE || op == OP_QUERY)
             && dest == '0) || (op == OP_ADD && chin == '0) || op == OP_BAD) begin
            add_result(KIND_REJECT, 1'b0, '0, '0, '0);
        end else begin
            case (op)
                OP_GRANT: begin
                    s = lookup(dest);
                    if (s >= 0) begin
                        if (count > 0) begin
                            pool_pop(ch);
                            pool_push(g_ch[s]);
                            g_ch[s] = ch;
                        end
                        g_src[s]  = src;
                        g_tmo[s]  = tmo;
                        g_elap[s] = '0;
                        add_result(KIND_ANSWER, 1'b1, g_ch[s], dest, src);
                    end else begin
                        s = 0;
                        while (s < SLOT_N && used[s]) s++;
                        if (s >= SLOT_N || count == 0) begin
                            add_result(KIND_ANSWER, 1'b0, '0, dest, '0);
                        end else begin
                            used[s]   = 1'b1;
                            g_dest[s] = dest;
                            g_src[s]  = src;
                            pool_pop(g_ch[s]);
                            g_tmo[s]  = tmo;
                            g_elap[s] = '0;
                            granted++;
                            add_result(KIND_ANSWER, 1'b1, g_ch[s], dest, src);
                        end
                    end
                end
                OP_TOUCH, OP_QUERY: begin
                    s = lookup(dest);
                    if (s >= 0) begin
                        if (op == OP_TOUCH) g_elap[s] = '0;
                        add_result(KIND_ANSWER, 1'b1, g_ch[s], dest, g_src[s]);
                    end else begin
                        add_result(KIND_ANSWER, 1'b0, '0, dest, '0);
                    end
                end
                OP_RELEASE: begin
                    s = lookup(dest);
                    if (s >= 0) free_slot(s);
                    else add_result(KIND_ANSWER, 1'b0, '0, dest, '0);
                end
                OP_REL_ALL: begin
                    for (int i = 0; i < SLOT_N; i++)
                        if (used[i]) free_slot(i);
                    add_result(KIND_END, 1'b1, '0, '0, '0);
                end
                OP_TICK: begin
                    // advance every running lease, then release in slot order
                    for (int i = 0; i < SLOT_N; i++) begin
                        expired[i] = 1'b0;
                        if (used[i]) begin
                            sum = {1'b0, g_elap[i]} + ms;
                            if (sum > {1'b0, ELAPSED_SAT}) sum = {1'b0, ELAPSED_SAT};
                            g_elap[i] = sum[ELAPSED_W-1:0];
                            if (g_tmo[i] != '0 && longint'(sum) >= longint'(g_tmo[i]) * TPS)
                                expired[i] = 1'b1;
                        end
                    end
                    for (int i = 0; i < SLOT_N; i++)
                        if (expired[i]) free_slot(i);
                    add_result(KIND_END, 1'b1, '0, '0, '0);
                end
                default: begin
                    if (count < POOL_N) begin
                        pool_push(chin);
                        add_result(KIND_ANSWER, 1'b1, chin, '0, '0);
                    end else begin
                        add_result(KIND_ANSWER, 1'b0, chin, '0, '0);
                    end
                end
            endcase
        end
        expected_results[$].last = 1'b1;
    endtask

    // Compare results first, then record the transfer accepted at this edge
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            head         = 0;
            count        = 0;
            granted      = 0;
            o_fail_count = 0;
            for (int i = 0; i < SLOT_N; i++) used[i] = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.ok     = m_tdata[0];
                got.ch     = m_tdata[12:1];
                got.dest   = m_tdata[36:13];
                got.src    = m_tdata[60:37];
                got.active = m_tdata[65:61];
                got.last   = m_tlast;
                if (expected_results.size() == 0) begin
                    $display({"%0t: unexpected result kind=%0d ok=%0d ch=%0d dest=%h",
                              " src=%h act=%0d last=%0d"},
                             $time, got.kind, got.ok, got.ch, got.dest, got.src,
                             got.active, got.last);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch expected kind=%0d ok=%0d ch=%0d",
                                  " dest=%h src=%h act=%0d last=%0d"},
                                 $time, want.kind, want.ok, want.ch, want.dest, want.src,
                                 want.active, want.last);
                        $display({"%0t:          actual   kind=%0d ok=%0d ch=%0d",
                                  " dest=%h src=%h act=%0d last=%0d"},
                                 $time, got.kind, got.ok, got.ch, got.dest, got.src,
                                 got.active, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_grant_pool(s_tuser, s_tdata[23:0], s_tdata[47:24],
                                   s_tdata[63:48], s_tdata[79:64], s_tdata[91:80]);
        end
    end

endmodule

[tb/sv/channel_grant_pool_with_timeouts_tb.sv]
`timescale 1ns / 1ps

module channel_grant_pool_with_timeouts_tb
    import cgp_pkg::*;
();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = OP_GRANT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    int burst_left = 0;
    bit hold_off_req = 0;

    always #6 i_clk = ~i_clk;

    channel_grant_pool_with_timeouts DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    channel_grant_pool_with_timeouts_chk CHK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one transfer, in bursts with random gaps, and hold until accepted
    task automatic send_op(logic [2:0] op, logic [23:0] dest, logic [23:0] src,
                           logic [15:0] tmo, logic [15:0] ms, logic [11:0] chin);
        @(negedge i_clk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 5);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, chin, ms, tmo, src, dest};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_dest();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom);
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(1, 20));
        endcase
    endfunction

    // Receiver: runs of ready and stalls, plus one long hold-off on request
    initial begin
        int len;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end else begin
                len = $urandom_range(1, 10);
                m_tready <= ($urandom_range(0, 2) != 0);
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        logic [2:0]  op;
        logic [15:0] tmo;
        logic [15:0] ms;
        logic [11:0] chin;
        int          pick;
        int          wait_cycles;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejects, extremes, every operation, and hits and misses of grant, touch and release
        send_op(OP_ADD, 24'd0, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_GRANT, 24'd5, 24'd1, 16'd1, 16'd0, 12'd0);
        send_op(OP_ADD, 24'd0, 24'd0, 16'd0, 16'd0, 12'hFFF);
        send_op(OP_ADD, 24'd0, 24'd0, 16'd0, 16'd0, 12'd1);
        send_op(OP_ADD, 24'd0, 24'd0, 16'd0, 16'd0, 12'd2);
        send_op(OP_GRANT, 24'd0, 24'd7, 16'd3, 16'd0, 12'd0);
        send_op(OP_GRANT, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
        send_op(OP_GRANT, 24'd1, 24'd9, 16'd0, 16'd0, 12'd0);
        send_op(OP_GRANT, 24'd2, 24'd3, 16'd1, 16'd0, 12'd0);
        send_op(OP_GRANT, 24'd3, 24'd3, 16'd1, 16'd0, 12'd0);
        send_op(OP_GRANT, 24'd1, 24'd4, 16'd2, 16'd0, 12'd0);
        send_op(OP_TOUCH, 24'd2, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_TOUCH, 24'd9, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_QUERY, 24'hFFFFFF, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_QUERY, 24'd0, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_TICK, 24'd0, 24'd0, 16'd0, 16'd1500, 12'd0);
        send_op(OP_TICK, 24'd0, 24'd0, 16'd0, 16'hFFFF, 12'd0);
        send_op(OP_RELEASE, 24'd1, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_RELEASE, 24'd1, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_RELEASE, 24'd0, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_BAD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
        send_op(OP_GRANT, 24'd8, 24'd8, 16'd0, 16'd0, 12'd0);
        send_op(OP_REL_ALL, 24'd0, 24'd0, 16'd0, 16'd0, 12'd0);
        send_op(OP_REL_ALL, 24'd0, 24'd0, 16'd0, 16'd0, 12'd0);

        // random: weighted toward grants and pool refills so the table fills
        for (int n = 0; n < 480; n++) begin
            if (n == 200) hold_off_req = 1;
            pick = $urandom_range(0, 99);
            if      (pick < 28) op = OP_GRANT;
            else if (pick < 36) op = OP_TOUCH;
            else if (pick < 48) op = OP_RELEASE;
            else if (pick < 51) op = OP_REL_ALL;
            else if (pick < 66) op = OP_TICK;
            else if (pick < 89) op = OP_ADD;
            else if (pick < 97) op = OP_QUERY;
            else                op = OP_BAD;
            tmo  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
            ms   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
            chin = ($urandom_range(0, 30) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
            send_op(op, ($urandom_range(0, 40) == 0) ? 24'd0 : pick_dest(),
                    24'($urandom), tmo, ms, chin);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30ms;
        $display("status: fail");
        $finish;
    end

endmodule
